FILE: design/tmg_pkg.sv
// ----------------------------------------------------------------------------
// tmg_pkg: shared definitions for the HDR pixel tonemapper
// Holds the payload types, the fixed-point widths, the filmic coefficients
// and the function that builds the gamma table entries.
// ----------------------------------------------------------------------------
package tmg_pkg;

	// Channel format, settled by the payload fields.
	localparam int FRAC_BITS = 16;
	localparam int INT_BITS  = 8;
	localparam int IN_W      = INT_BITS + FRAC_BITS;
	localparam int BYTE_W    = 8;
	localparam int NUM_CH    = 3;

	// Default gamma table index width.
	localparam int GAMMA_INDEX_BITS = 10;

	// Q0.16 tonemap value, one bit more so that 1.0 fits.
	localparam int Q16_BITS  = 16;
	localparam int T_W       = Q16_BITS + 1;
	localparam int ONE_Q16   = 1 << Q16_BITS;
	localparam int G_W       = Q16_BITS + 1;

	// Datapath widths.
	localparam int X_W       = FRAC_BITS + 4;
	localparam int WIDE_W    = (IN_W > X_W) ? IN_W : X_W;
	localparam int XX_W      = 2 * X_W;
	localparam int SQ_W      = FRAC_BITS + 8;
	localparam int K_W       = FRAC_BITS + 2;
	localparam int DEN_W     = 2 * FRAC_BITS + 10;
	localparam int PB_W      = K_W + X_W;
	localparam int SC_W      = G_W + BYTE_W;

	// Queue between the front and the back.
	localparam int Q_DEPTH   = 4;

	// Output scaling.
	localparam int SCALE_MAX  = 255;
	localparam int ROUND_HALF = 32768;

	// Filmic fit coefficients, rounded half up to FRAC_BITS.
	localparam logic [K_W-1:0] K_A = K_W'(((64'd251 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [K_W-1:0] K_B = K_W'(((64'd3 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [K_W-1:0] K_C = K_W'(((64'd243 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [K_W-1:0] K_D = K_W'(((64'd59 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [K_W-1:0] K_E = K_W'(((64'd14 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [X_W-1:0] X_LIMIT = X_W'(64'd8 << FRAC_BITS);

	// Input and result items.
	typedef struct packed {
		logic [IN_W-1:0] red_in;
		logic [IN_W-1:0] green_in;
		logic [IN_W-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red_byte;
		logic [BYTE_W-1:0] green_byte;
		logic [BYTE_W-1:0] blue_byte;
	} pix_out_t;

	// One channel's ratio as it waits for the divider.
	typedef struct packed {
		logic             sat;
		logic [DEN_W-1:0] num;
		logic [DEN_W-1:0] den;
	} chan_frac_t;

	typedef chan_frac_t [NUM_CH-1:0] frac_set_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Largest y in 0..65536 with (y/65536)^11 <= (i/2^gb)^5.
	function automatic logic [G_W-1:0] gamma_entry(int unsigned i, int unsigned gb);
		logic [255:0] rhs;
		logic [255:0] lhs;
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  mid;
		rhs = 256'd1;
		for (int k = 0; k < 5; k++) begin
			rhs = rhs * 256'(i);
		end
		rhs = rhs << (11 * Q16_BITS);
		lo = 0;
		hi = ONE_Q16;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			lhs = 256'd1;
			for (int k = 0; k < 11; k++) begin
				lhs = lhs * 256'(mid);
			end
			lhs = lhs << (5 * gb);
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return G_W'(lo);
	endfunction

endpackage

FILE: design/tmg_front.sv
// ----------------------------------------------------------------------------
// tmg_front: filmic numerator and denominator
// Accepts pixels, clamps each channel, forms the numerator and denominator
// of the filmic fit and flags channels that saturate at 1.0.
// ----------------------------------------------------------------------------
module tmg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  tmg_pkg::pix_in_t   pixel,
	input  tmg_pkg::q_status_t q_stat,
	output logic               push,
	output tmg_pkg::frac_set_t push_data
);
	import tmg_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [IN_W-1:0] raw [NUM_CH];

	// The pipeline moves unless its last item cannot enter the queue.
	assign en          = !(v_s5 && q_stat.full);
	assign pixel_stall = !en;
	assign push        = v_s5 && !q_stat.full;

	assign raw[0] = pixel.red_in;
	assign raw[1] = pixel.green_in;
	assign raw[2] = pixel.blue_in;

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// One lane per color channel.
	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		logic [WIDE_W-1:0] raw_w;
		logic [X_W-1:0]    x_c;
		logic [X_W-1:0]    x_s1, x_s2, x_s3;
		logic [XX_W-1:0]   xx_s2;
		logic [XX_W:0]     sq_sum;
		logic [SQ_W-1:0]   sq_s3;
		logic [DEN_W-1:0]  pa_s4, pc_s4;
		logic [PB_W-1:0]   pb_s4, pd_s4;
		logic [DEN_W-1:0]  num_c, den_c;
		logic [DEN_W-1:0]  num_s5, den_s5;
		logic              sat_s5;

		// Radiance at or above 8.0 acts as 8.0.
		assign raw_w = WIDE_W'(raw[c]);
		assign x_c   = (raw_w > WIDE_W'(X_LIMIT)) ? X_LIMIT : X_W'(raw_w);

		// Square rounded back to FRAC_BITS.
		assign sq_sum = (XX_W+1)'(xx_s2) + ((XX_W+1)'(1) << (FRAC_BITS - 1));

		// Numerator and denominator sums.
		assign num_c = pa_s4 + DEN_W'(pb_s4);
		assign den_c = pc_s4 + DEN_W'(pd_s4) + (DEN_W'(K_E) << FRAC_BITS);

		always_ff @(posedge clk) begin
			if (en) begin
				x_s1   <= x_c;
				xx_s2  <= XX_W'(x_s1) * XX_W'(x_s1);
				x_s2   <= x_s1;
				sq_s3  <= SQ_W'(sq_sum >> FRAC_BITS);
				x_s3   <= x_s2;
				pa_s4  <= DEN_W'(K_A) * DEN_W'(sq_s3);
				pc_s4  <= DEN_W'(K_C) * DEN_W'(sq_s3);
				pb_s4  <= PB_W'(K_B) * PB_W'(x_s3);
				pd_s4  <= PB_W'(K_D) * PB_W'(x_s3);
				num_s5 <= num_c;
				den_s5 <= den_c;
				sat_s5 <= (num_c >= den_c);
			end
		end

		assign push_data[c].sat = sat_s5;
		assign push_data[c].num = num_s5;
		assign push_data[c].den = den_s5;
	end

endmodule

FILE: design/tmg_queue.sv
// ----------------------------------------------------------------------------
// tmg_queue: short queue between front and back
// A small register queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module tmg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tmg_pkg::frac_set_t push_data,
	input  logic               pop,
	output tmg_pkg::frac_set_t head,
	output tmg_pkg::q_status_t q_stat
);
	import tmg_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	frac_set_t        mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CNT_W'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: design/tmg_back.sv
// ----------------------------------------------------------------------------
// tmg_back: divider, gamma lookup and quantizer
// Divides numerator by denominator one quotient bit per stage, interpolates
// the gamma table and scales the result to a display byte.
// ----------------------------------------------------------------------------
module tmg_back #(
	parameter int GAMMA_TABLE_INDEX_BITS = tmg_pkg::GAMMA_INDEX_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tmg_pkg::q_status_t q_stat,
	input  tmg_pkg::frac_set_t head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output tmg_pkg::pix_out_t  result
);
	import tmg_pkg::*;

	localparam int GB    = GAMMA_TABLE_INDEX_BITS;
	localparam int N     = 1 << GB;
	localparam int IW    = GB + 1;
	localparam int SH    = Q16_BITS - GB;
	localparam int STEPS = Q16_BITS;
	localparam int S_ROM = STEPS + 1;
	localparam int LAST  = STEPS + 4;

	logic              en;
	logic              vld_s [0:LAST];
	logic [BYTE_W-1:0] byte_out [NUM_CH];

	// The whole back pipeline holds while the result waits.
	assign en           = !(vld_s[LAST] && result_stall);
	assign pop          = en && !q_stat.empty;
	assign result_valid = vld_s[LAST];

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= !q_stat.empty;
			for (int k = 1; k <= LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// One lane per color channel.
	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		logic [DEN_W-1:0]    rem_s [0:STEPS];
		logic [DEN_W-1:0]    den_s [0:STEPS];
		logic [STEPS-1:0]    quo_s [0:STEPS];
		logic                sat_s [0:STEPS];
		logic [G_W-1:0]      rom_w [0:N];
		logic [T_W-1:0]      t_c;
		logic [IW-1:0]       idx_c, idx_nx_c;
		logic [G_W-1:0]      g0_s17, g1_s17, g0_s18, g_s19;
		logic [SH-1:0]       frac_s17;
		logic [G_W-1:0]      diff_c;
		logic [G_W+SH-1:0]   prod_s18;
		logic [SC_W-1:0]     scaled_c;
		logic [BYTE_W:0]     upper_c;
		logic [BYTE_W-1:0]   byte_s20;

		// Gamma table, one constant per entry.
		for (genvar e = 0; e <= N; e++) begin : g_rom
			localparam logic [G_W-1:0] ENTRY = gamma_entry(e, GB);
			assign rom_w[e] = ENTRY;
		end

		// Load from the queue head.
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0] <= head[c].num;
				den_s[0] <= head[c].den;
				sat_s[0] <= head[c].sat;
				quo_s[0] <= '0;
			end
		end

		// Restoring division, one quotient bit per stage.
		for (genvar k = 1; k <= STEPS; k++) begin : g_div
			logic [DEN_W:0] r2;
			logic           take;
			assign r2   = {rem_s[k-1], 1'b0};
			assign take = (r2 >= {1'b0, den_s[k-1]});
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? DEN_W'(r2 - {1'b0, den_s[k-1]}) : DEN_W'(r2);
					quo_s[k] <= {quo_s[k-1][STEPS-2:0], take};
					den_s[k] <= den_s[k-1];
					sat_s[k] <= sat_s[k-1];
				end
			end
		end

		// Tonemap value, table index and interpolation fraction.
		assign t_c      = sat_s[STEPS] ? T_W'(ONE_Q16) : {1'b0, quo_s[STEPS]};
		assign idx_c    = IW'(t_c >> SH);
		assign idx_nx_c = (idx_c == IW'(N)) ? idx_c : idx_c + 1'b1;

		// The table never falls, but a difference below zero counts as none.
		assign diff_c = (g1_s17 >= g0_s17) ? (g1_s17 - g0_s17) : '0;

		// Scale by 255 and round half up.
		assign scaled_c = SC_W'(g_s19) * SC_W'(SCALE_MAX) + SC_W'(ROUND_HALF);
		assign upper_c  = scaled_c[SC_W-1:Q16_BITS];

		always_ff @(posedge clk) begin
			if (en) begin
				g0_s17   <= rom_w[idx_c];
				g1_s17   <= rom_w[idx_nx_c];
				frac_s17 <= t_c[SH-1:0];
				prod_s18 <= (G_W+SH)'(diff_c) * (G_W+SH)'(frac_s17);
				g0_s18   <= g0_s17;
				g_s19    <= g0_s18 + G_W'(prod_s18 >> SH);
				byte_s20 <= (upper_c > (BYTE_W+1)'(SCALE_MAX)) ? BYTE_W'(SCALE_MAX)
				                                              : upper_c[BYTE_W-1:0];
			end
		end

		assign byte_out[c] = byte_s20;
	end

	assign result.red_byte   = byte_out[0];
	assign result.green_byte = byte_out[1];
	assign result.blue_byte  = byte_out[2];

endmodule

FILE: design/hdr_pixel_tonemap_gamma_quantize.sv
// ----------------------------------------------------------------------------
// hdr_pixel_tonemap_gamma_quantize: ACES filmic tonemap, gamma 1/2.2, 8 bits
// From an accepted pixel to its result the path runs through 5 front stages,
// the queue, a load stage, 16 divider stages and 4 gamma stages.
// Throughput is one pixel per cycle while result_stall is low, as the
// divider is pipelined one quotient bit per stage.
// A four-item queue lets the front keep accepting while a result waits.
// Reset clears the valid bits and queue pointers; the gamma table is constant.
// ----------------------------------------------------------------------------
module hdr_pixel_tonemap_gamma_quantize #(
	parameter int GAMMA_TABLE_INDEX_BITS = tmg_pkg::GAMMA_INDEX_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  tmg_pkg::pix_in_t  pixel,
	output logic              result_valid,
	input  logic              result_stall,
	output tmg_pkg::pix_out_t result
);
	import tmg_pkg::*;

	logic      q_push;
	logic      q_pop;
	frac_set_t q_in;
	frac_set_t q_head;
	q_status_t q_stat;

	// Front: clamp and filmic sums.
	tmg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.q_stat      (q_stat),
		.push        (q_push),
		.push_data   (q_in)
	);

	// Queue between the two halves.
	tmg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.q_stat    (q_stat)
	);

	// Back: divide, gamma and quantize.
	tmg_back #(
		.GAMMA_TABLE_INDEX_BITS (GAMMA_TABLE_INDEX_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head         (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// The queue is never written while full.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue written while full");

	// The queue is never read while empty.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue read while empty");

	// A push into an empty queue makes it non-empty in the next cycle.
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_stat.empty) |=> !q_stat.empty)
		else $error("queue lost an item");

endmodule
